### src/egsa_pkg.sv
// Shared types and constants for the embedding gradient scatter-add block.
`default_nettype none
package egsa_pkg;

  // Default capacity of the gradient table
  localparam int unsigned MaxRowsDef     = 256;
  localparam int unsigned MaxRowWidthDef = 16;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Register field widths
  localparam int unsigned VocabW = 9;
  localparam int unsigned RwidW  = 5;
  localparam int unsigned TokW   = 16;
  localparam int unsigned ColW   = 4;
  localparam int unsigned ValW   = 32;

  // Compare widths wide enough for any legal capacity
  localparam int unsigned RowCmpW = 17;
  localparam int unsigned WidCmpW = 11;

  // Stream payload widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegVocab   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRowWid  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPadding = 2'd2;

  // Item kinds
  typedef enum logic {
    KIND_ACC  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write zero at the sweep address
    logic load;    // capture and decode an input beat
    logic update;  // finish the item: write back and fill the output register
  } egsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep is at the last table entry
  } egsa_status_t;

endpackage
`default_nettype wire

### src/egsa_ctrl.sv
// Controller state machine: table clearing sweep and per-item sequencing.
`default_nettype none
module egsa_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire egsa_pkg::egsa_status_t status_i,
  output egsa_pkg::egsa_cmd_t        cmd_o
);
  import egsa_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // Output register can take a new result this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.clear  = (state_q == ST_CLEAR);
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.update = (state_q == ST_UPD) && slot_free;
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/egsa_dp.sv
// Datapath: configuration registers, item decode, gradient table and saturating add.
`default_nettype none
module egsa_dp #(
  parameter int unsigned MAX_ROWS      = egsa_pkg::MaxRowsDef,
  parameter int unsigned MAX_ROW_WIDTH = egsa_pkg::MaxRowWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [egsa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [egsa_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          kind_i,
  input  wire logic [egsa_pkg::TokW-1:0]     token_index_i,
  input  wire logic [egsa_pkg::ColW-1:0]     column_i,
  input  wire logic signed [egsa_pkg::ValW-1:0] grad_value_i,
  input  wire egsa_pkg::egsa_cmd_t           cmd_i,
  output egsa_pkg::egsa_status_t             status_o,
  output logic signed [egsa_pkg::ValW-1:0]   entry_value_o,
  output logic                               padding_skipped_o,
  output logic                               index_remapped_o,
  output logic                               column_error_o,
  output logic                               saturated_o
);
  import egsa_pkg::*;

  localparam int unsigned Depth = MAX_ROWS * MAX_ROW_WIDTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowW  = $clog2(MAX_ROWS);
  localparam logic [RowCmpW-1:0] RowsCap  = RowCmpW'(MAX_ROWS);
  localparam logic [WidCmpW-1:0] WidthCap = WidCmpW'(MAX_ROW_WIDTH);
  localparam logic [AddrW-1:0]   LastAddr = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0]   RowStep  = AddrW'(MAX_ROW_WIDTH);
  localparam logic [ValW-1:0]    QMax     = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0]    QMin     = {1'b1, {(ValW-1){1'b0}}};

  // Configuration registers
  logic [VocabW-1:0] vocab_q;
  logic [RwidW-1:0]  rwid_q;
  logic [VocabW-1:0] pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= VocabW'(256);
      rwid_q  <= RwidW'(16);
      pad_q   <= VocabW'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegVocab:   vocab_q <= cfg_data_i[VocabW-1:0];
        RegRowWid:  rwid_q  <= cfg_data_i[RwidW-1:0];
        RegPadding: pad_q   <= cfg_data_i[VocabW-1:0];
        default:    ;
      endcase
    end
  end

  // Decode the incoming beat: limits, remap, column check, padding check
  logic [RowCmpW-1:0] vocab_ext, vocab_lim, pad_ext, row_ext;
  logic [WidCmpW-1:0] width_ext, width_lim;
  logic               dec_remap, dec_colerr, dec_skip;
  logic [RowW-1:0]    dec_row;
  logic [AddrW-1:0]   dec_addr;

  always_comb begin
    vocab_ext  = RowCmpW'(vocab_q);
    vocab_lim  = (vocab_ext > RowsCap) ? RowsCap : vocab_ext;
    width_ext  = WidCmpW'(rwid_q);
    width_lim  = (width_ext > WidthCap) ? WidthCap : width_ext;
    pad_ext    = RowCmpW'(pad_q);
    dec_remap  = RowCmpW'(token_index_i) >= vocab_lim;
    dec_row    = dec_remap ? '0 : token_index_i[RowW-1:0];
    row_ext    = RowCmpW'(dec_row);
    dec_colerr = WidCmpW'(column_i) >= width_lim;
    dec_skip   = (kind_i == KIND_ACC) && !dec_colerr
                 && (pad_ext < vocab_lim) && (row_ext == pad_ext);
    dec_addr   = AddrW'(AddrW'(dec_row) * RowStep + AddrW'(column_i));
  end

  // Item registers
  logic [AddrW-1:0]       addr_q;
  logic                   kind_q, remap_q, colerr_q, skip_q;
  logic signed [ValW-1:0] grad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q   <= dec_addr;
      kind_q   <= kind_i;
      remap_q  <= dec_remap;
      colerr_q <= dec_colerr;
      skip_q   <= dec_skip;
      grad_q   <= grad_value_i;
    end
  end

  // Clearing sweep address
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  assign status_o.clear_last = (clr_cnt_q == LastAddr);

  // Saturating add of the stored entry and the gradient
  logic [ValW-1:0]  rdata_q;
  logic [ValW:0]    sum_w;
  logic             sum_ovf;
  logic [ValW-1:0]  sum_sat;

  always_comb begin
    sum_w   = {rdata_q[ValW-1], rdata_q} + {grad_q[ValW-1], grad_q};
    sum_ovf = sum_w[ValW] != sum_w[ValW-1];
    sum_sat = sum_ovf ? (sum_w[ValW] ? QMin : QMax) : sum_w[ValW-1:0];
  end

  // Table write port: sweep or write-back
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [ValW-1:0]  mem_wdata;
  logic             do_acc;

  assign do_acc    = (kind_q == KIND_ACC) && !colerr_q && !skip_q;
  assign mem_we    = cmd_i.clear || (cmd_i.update && do_acc);
  assign mem_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : sum_sat;

  // Gradient table with registered read
  logic [ValW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      index_remapped_o  <= remap_q;
      column_error_o    <= colerr_q;
      padding_skipped_o <= skip_q && !colerr_q;
      saturated_o       <= do_acc && sum_ovf;
      if (colerr_q) begin
        entry_value_o <= '0;
      end else if (do_acc) begin
        entry_value_o <= sum_sat;
      end else begin
        entry_value_o <= rdata_q;
      end
    end
  end

endmodule
`default_nettype wire

### src/embedding_gradient_scatter_add.sv
// Top level of the embedding gradient scatter-add block.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata token, column, grad; tuser kind
//  m_axis   | out       | m_axis_tvalid/tready    | tdata entry value and four flags
//  cfg      | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// An item goes through capture and decode, table read, then write-back and
// output load, all set by the read-modify-write of the table memory, whose read is registered.
// After reset the table is swept to zero entry by entry, during
// which no beat is taken; configuration writes are taken at any time.
// A stalled output holds the finished item in its write-back step until the beat leaves.
`default_nettype none
module embedding_gradient_scatter_add #(
  parameter int unsigned MAX_ROWS      = egsa_pkg::MaxRowsDef,
  parameter int unsigned MAX_ROW_WIDTH = egsa_pkg::MaxRowWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [egsa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [egsa_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // token_index [15:0], column [19:16], grad_value [51:20], zero [55:52]
  input  wire logic [egsa_pkg::InDataW-1:0]   s_axis_tdata,
  // kind [0]
  input  wire logic                           s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // entry_value [31:0], padding_skipped [32], index_remapped [33],
  // column_error [34], saturated [35], zero [39:36]
  output logic [egsa_pkg::OutDataW-1:0]       m_axis_tdata
);
  import egsa_pkg::*;

  egsa_cmd_t              cmd;
  egsa_status_t           status;
  logic signed [ValW-1:0] entry_value;
  logic                   padding_skipped, index_remapped, column_error, saturated;

  egsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  egsa_dp #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (s_axis_tuser),
    .token_index_i     (s_axis_tdata[15:0]),
    .column_i          (s_axis_tdata[19:16]),
    .grad_value_i      (s_axis_tdata[51:20]),
    .cmd_i             (cmd),
    .status_o          (status),
    .entry_value_o     (entry_value),
    .padding_skipped_o (padding_skipped),
    .index_remapped_o  (index_remapped),
    .column_error_o    (column_error),
    .saturated_o       (saturated)
  );

  // Pack the result beat
  assign m_axis_tdata = {4'b0000, saturated, column_error, index_remapped,
                         padding_skipped, entry_value};

endmodule
`default_nettype wire

### bench/scatter_add_checker.sv
// Checker for the gradient scatter-add block: models the table, predicts each result beat, compares.
module scatter_add_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [egsa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [egsa_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  // token_index [15:0], column [19:16], grad_value [51:20], zero [55:52]
  input  logic [egsa_pkg::InDataW-1:0]    in_data_i,
  // kind [0]
  input  logic                            in_user_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  // entry_value [31:0], padding_skipped [32], index_remapped [33],
  // column_error [34], saturated [35], zero [39:36]
  input  logic [egsa_pkg::OutDataW-1:0]   out_data_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  import egsa_pkg::*;

  localparam int unsigned TableDepth = MaxRowsDef * MaxRowWidthDef;
  localparam int unsigned TableAddrW = $clog2(TableDepth);
  localparam longint      QMax       = 64'sd2147483647;
  localparam longint      QMin       = -64'sd2147483648;

  // Field order matches the low 36 bits of the result beat, MSB first
  typedef struct packed {
    logic            saturated;
    logic            column_error;
    logic            index_remapped;
    logic            padding_skipped;
    logic [ValW-1:0] entry_value;
  } entry_result_t;

  logic [ValW-1:0]   grad_table [TableDepth];
  logic [VocabW-1:0] vocab_reg;
  logic [RwidW-1:0]  width_reg;
  logic [VocabW-1:0] pad_reg;
  entry_result_t     expected_entries [$];

  // Apply one item to the table copy and return the beat it should produce
  function automatic entry_result_t apply_gradient_item(input kind_e kind,
                                                        input logic [TokW-1:0] token,
                                                        input logic [ColW-1:0] col,
                                                        input logic [ValW-1:0] grad);
    entry_result_t         res;
    int unsigned           vocab_lim;
    int unsigned           width_lim;
    int unsigned           row;
    logic [TableAddrW-1:0] addr;
    longint                sum;
    res       = '0;
    vocab_lim = (32'(vocab_reg) > MaxRowsDef) ? MaxRowsDef : 32'(vocab_reg);
    width_lim = (32'(width_reg) > MaxRowWidthDef) ? MaxRowWidthDef : 32'(width_reg);
    row       = 32'(token);
    if (row >= vocab_lim) begin
      row                = 0;
      res.index_remapped = 1'b1;
    end
    if (32'(col) >= width_lim) begin
      res.column_error = 1'b1;
    end else begin
      addr            = TableAddrW'(row * MaxRowWidthDef + 32'(col));
      res.entry_value = grad_table[addr];
      if (kind == KIND_ACC) begin
        if (32'(pad_reg) < vocab_lim && row == 32'(pad_reg)) begin
          res.padding_skipped = 1'b1;
        end else begin
          sum = longint'($signed(res.entry_value)) + longint'($signed(grad));
          if (sum > QMax) begin
            sum           = QMax;
            res.saturated = 1'b1;
          end else if (sum < QMin) begin
            sum           = QMin;
            res.saturated = 1'b1;
          end
          res.entry_value  = 32'(sum);
          grad_table[addr] = res.entry_value;
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  // Track config writes, check result beats against the oldest prediction, queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    entry_result_t want;
    entry_result_t got;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < TableDepth; i++) grad_table[TableAddrW'(i)] = '0;
      vocab_reg = 9'd256;
      width_reg = 5'd16;
      pad_reg   = 9'd256;
      expected_entries.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegVocab:   vocab_reg = cfg_data_i;
          RegRowWid:  width_reg = cfg_data_i[RwidW-1:0];
          RegPadding: pad_reg   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[35:0];
        if (expected_entries.size() == 0) begin
          $error("result beat with nothing expected: %h", out_data_i);
          fail_count_o++;
        end else begin
          want = expected_entries.pop_front();
          check_field("entry_value", want.entry_value, got.entry_value);
          check_field("padding_skipped", ValW'(want.padding_skipped),
                      ValW'(got.padding_skipped));
          check_field("index_remapped", ValW'(want.index_remapped),
                      ValW'(got.index_remapped));
          check_field("column_error", ValW'(want.column_error),
                      ValW'(got.column_error));
          check_field("saturated", ValW'(want.saturated), ValW'(got.saturated));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_entries.push_back(apply_gradient_item(kind_e'(in_user_i),
                                                       in_data_i[15:0],
                                                       in_data_i[19:16],
                                                       in_data_i[51:20]));
      end
      pending_o = expected_entries.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the gradient scatter-add bench: clock, reset, stimulus, pacing and the verdict.
module testbench;
  import egsa_pkg::*;

  localparam int unsigned CycleLimit     = 120000;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned ItemsPerPhase  = 180;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // token_index [15:0], column [19:16], grad_value [51:20], zero [55:52]
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  // kind [0]
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // entry_value [31:0], padding_skipped [32], index_remapped [33],
  // column_error [34], saturated [35], zero [39:36]
  logic [OutDataW-1:0]  m_axis_tdata;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned cur_vocab    = 256;
  int unsigned cur_width    = 16;
  int unsigned cur_pad      = 256;

  embedding_gradient_scatter_add dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scatter_add_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #4 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic send_item(input kind_e kind, input logic [TokW-1:0] token,
                           input logic [ColW-1:0] col, input logic [ValW-1:0] grad);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, grad, col, token};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned vocab, input int unsigned width,
                           input int unsigned pad);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegVocab;
    cfg_data_i  <= 9'(vocab);
    @(posedge clk_i);
    cfg_index_i <= RegRowWid;
    cfg_data_i  <= 9'(width);
    @(posedge clk_i);
    cfg_index_i <= RegPadding;
    cfg_data_i  <= 9'(pad);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_vocab = vocab;
    cur_width = width;
    cur_pad   = pad;
  endtask

  // One setting with its pacing: random items biased to hot entries, padding and edges
  task automatic run_phase(input int unsigned vocab, input int unsigned width,
                           input int unsigned pad, input int unsigned tx,
                           input int unsigned rx, input bit hold_off);
    kind_e           kind;
    logic [TokW-1:0] token;
    logic [ColW-1:0] col;
    logic [ValW-1:0] grad;
    int unsigned     vocab_lim;
    int unsigned     width_lim;
    int unsigned     r;
    write_cfg(vocab, width, pad);
    tx_idle_pct  <= tx;
    rx_stall_pct <= rx;
    if (hold_off) hold_reqs <= hold_reqs + 1;
    vocab_lim = (cur_vocab > MaxRowsDef) ? MaxRowsDef : cur_vocab;
    width_lim = (cur_width > MaxRowWidthDef) ? MaxRowWidthDef : cur_width;
    for (int i = 0; i < ItemsPerPhase; i++) begin
      kind = ($urandom_range(99) < 25) ? KIND_READ : KIND_ACC;
      r = $urandom_range(99);
      if (r < 35) token = 16'($urandom_range(3));
      else if (r < 60) token = (vocab_lim != 0) ? 16'($urandom_range(vocab_lim - 1)) : 16'd0;
      else if (r < 70) token = 16'(cur_pad);
      else if (r < 80) token = 16'(vocab_lim + $urandom_range(3));
      else token = 16'($urandom_range(65535));
      r = $urandom_range(99);
      if (r < 35) col = 4'($urandom_range(1));
      else if (r < 75 && width_lim != 0) col = 4'($urandom_range(width_lim - 1));
      else col = 4'($urandom_range(15));
      r = $urandom_range(99);
      if (r < 20) grad = 32'($urandom_range(262143));
      else if (r < 40) grad = 32'd0 - 32'($urandom_range(262143));
      else if (r < 70) grad = $urandom();
      else if (r < 80) grad = 32'h7FFF_FFFF;
      else if (r < 90) grad = 32'h8000_0000;
      else if (r < 95) grad = 32'h0000_0000;
      else grad = 32'hFFFF_FFFF;
      send_item(kind, token, col, grad);
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: plain add, read back, both saturation limits, remapping
    send_item(KIND_ACC,  16'd5,      4'd3,  32'h0001_0000);
    send_item(KIND_READ, 16'd5,      4'd3,  32'hFFFF_FFFF);
    send_item(KIND_ACC,  16'd10,     4'd0,  32'h7FFF_FFFF);
    send_item(KIND_ACC,  16'd10,     4'd0,  32'h7FFF_FFFF);
    send_item(KIND_ACC,  16'd11,     4'd15, 32'h8000_0000);
    send_item(KIND_ACC,  16'd11,     4'd15, 32'hFFFF_FFFF);
    send_item(KIND_ACC,  16'd255,    4'd15, 32'hFFFF_FFFF);
    send_item(KIND_ACC,  16'd256,    4'd1,  32'h1234_5678);
    send_item(KIND_ACC,  16'hFFFF,   4'd1,  32'hEDCB_A988);
    send_item(KIND_READ, 16'd0,      4'd1,  32'h0000_0000);
    drain_results();

    // Padding on row zero catches remapped tokens; padding row still reads; column error
    write_cfg(8, 4, 0);
    send_item(KIND_ACC,  16'd20,     4'd2,  32'd5);
    send_item(KIND_ACC,  16'd0,      4'd2,  32'd5);
    send_item(KIND_READ, 16'd0,      4'd1,  32'd0);
    send_item(KIND_ACC,  16'd3,      4'd4,  32'd7);
    send_item(KIND_ACC,  16'd7,      4'd3,  32'hFFFF_FFFD);
    drain_results();

    // Empty vocabulary and zero row width
    write_cfg(0, 0, 256);
    send_item(KIND_ACC,  16'd0,      4'd0,  32'd1);
    send_item(KIND_READ, 16'd1,      4'd15, 32'd0);
    drain_results();

    // Sizes above capacity, padding disabled
    write_cfg(511, 31, 511);
    send_item(KIND_ACC,  16'd255,    4'd15, 32'd1);
    send_item(KIND_READ, 16'd300,    4'd15, 32'd0);
    send_item(KIND_ACC,  16'd4,      4'd0,  32'h7FFF_FFFF);
    drain_results();

    run_phase(256, 16, 256,  0,  0, 1'b0);
    run_phase(4,   4,  2,   64,  0, 1'b0);
    run_phase(1,   1,  0,    0, 64, 1'b0);
    run_phase(16,  16, 7,    0,  0, 1'b1);
    run_phase(300, 20, 511,  8,  8, 1'b0);
    run_phase(0,   0,  0,   64,  0, 1'b0);
    run_phase(200, 9,  199,  0, 64, 1'b0);
    run_phase(256, 16, 255,  8,  8, 1'b0);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
